// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/ibf_pkg.sv =====
// Types and constants of the invertible Bloom filter.
`default_nettype none
package ibf_pkg;
    localparam int KeyBits = 32;
    localparam int CtrBits = 8;
    localparam int CellBits = KeyBits + KeyBits * CtrBits;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_MODIFY,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/ibf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ibf_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ibf_cell_alu.sv =====
// Cell update and cell status logic.
`default_nettype none
module ibf_cell_alu (
    input  wire logic [ibf_pkg::CellBits-1:0] cell_in,
    input  wire logic [ibf_pkg::KeyBits-1:0]  key,
    input  wire logic                         sub,
    output logic      [ibf_pkg::CellBits-1:0] cell_new,
    output logic                              zero,
    output logic                              is_pure,
    output logic      [ibf_pkg::KeyBits-1:0]  pkey
);
    import ibf_pkg::*;

    logic [KeyBits-1:0] cnt;

    assign cnt = cell_in[KeyBits-1:0];

    // count in the low word, bit counter i above it
    always_comb
    begin
        logic [CtrBits-1:0] b;
        logic [CtrBits-1:0] d;
        cell_new[KeyBits-1:0] = sub ? cnt - KeyBits'(1) : cnt + KeyBits'(1);
        is_pure = (cnt != '0);
        for (int i = 0; i < KeyBits; i++)
        begin
            b = cell_in[KeyBits + i*CtrBits +: CtrBits];
            d = {{(CtrBits-1){1'b0}}, key[i]};
            cell_new[KeyBits + i*CtrBits +: CtrBits] = sub ? b - d : b + d;
            pkey[i] = (b != '0);
            if (b != '0 && {{(KeyBits-CtrBits){b[CtrBits-1]}}, b} != cnt)
            begin
                is_pure = 1'b0;
            end
        end
        zero = (cnt == '0) && (pkey == '0);
    end
endmodule
`default_nettype wire

// ===== rtl/invertible_bloom_filter_table_top.sv =====
// Top level of the invertible Bloom filter table.
//
// Usage: requests enter on s_axis (tdata = cmd, key, table_select,
// cell_index from bit 0 up); one result per request leaves on m_axis.
// Configuration: cfg_we/cfg_index/cfg_data write hash multipliers (0..3)
// and offsets (4..7); the user must write them while the block is idle; the block has no guard.
// Cell state sits in one RAM of NUM_HASHES * 2^LOG2_CELLS rows, each row a
// 32-bit count and 32 eight-bit counters, with a registered read.
// Sequence: add/remove/test pass through hash, read and modify/write for
// each sub-table in turn, then an output state; read cell passes through
// read and output only. One request is worked at a time, and the next is
// accepted once the result is loaded.
// After reset a clearing pass writes every row, one per cycle, with s_axis_tready low.
// The result sits in an output register; the next request is taken while
// it waits, and a stall of m_axis holds the block in its output cycle.
`default_nettype none
module invertible_bloom_filter_table_top #(
    parameter int NUM_HASHES = 4,
    parameter int LOG2_CELLS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // cmd, key, table_select, cell_index, pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // member, cell_count, cell_zero, cell_pure, pure_key, pad
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import ibf_pkg::*;

    localparam int TblBits = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
    localparam int Depth = NUM_HASHES << LOG2_CELLS;
    localparam int AddrBits = $clog2(Depth);

    logic [31:0] mult_reg [4];
    logic [31:0] offs_reg [4];
    state_t state_reg, state_next;
    logic [AddrBits-1:0] clr_reg;
    cmd_t cmd_reg;
    logic [KeyBits-1:0] key_reg;
    logic [1:0] tsel_reg;
    logic [TblBits:0] tbl_reg;
    logic member_reg;
    logic out_valid_reg, out_valid_next;
    logic [71:0] out_data_reg, out_data_next;
    logic [AddrBits-1:0] addr_reg;

    logic we;
    logic [AddrBits-1:0] waddr, raddr, read_addr, hash_addr;
    logic [CellBits-1:0] wdata, rdata, cell_new;
    logic zero, cell_is_pure;
    logic [KeyBits-1:0] pkey, hash;
    logic [LOG2_CELLS-1:0] cidx_low;
    logic [1:0] rsel;
    logic out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mult_reg[i] <= 32'd1;
                offs_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (!cfg_index[2]) mult_reg[cfg_index[1:0]] <= cfg_data;
            else offs_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    ibf_ram #(.Width(CellBits), .Depth(Depth)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    ibf_cell_alu u_alu (
        .cell_in(rdata), .key(key_reg), .sub(cmd_reg == CMD_REMOVE),
        .cell_new(cell_new), .zero(zero), .is_pure(cell_is_pure), .pkey(pkey)
    );

    assign rsel = tbl_reg[1:0];
    assign raddr = addr_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // row addresses: read cell from the request, sub-table cell from the hash
    assign hash = mult_reg[rsel] * key_reg + offs_reg[rsel];
    assign hash_addr = AddrBits'({tbl_reg[TblBits-1:0], hash[KeyBits-1 -: LOG2_CELLS]});
    assign cidx_low = LOG2_CELLS'(s_axis_tdata[45:36]);
    assign read_addr = (NUM_HASHES > 1) ? AddrBits'({s_axis_tdata[35:34], cidx_low})
                                        : AddrBits'(cidx_low);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == AddrBits'(Depth - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = (cmd_t'(s_axis_tdata[1:0]) == CMD_READ) ? ST_READ
                                                                        : ST_HASH;
            ST_HASH:   state_next = ST_READ;
            ST_READ:   state_next = (cmd_reg == CMD_READ) ? ST_OUT : ST_MODIFY;
            ST_MODIFY:
                state_next = (tbl_reg == (TblBits+1)'(NUM_HASHES - 1)) ? ST_OUT
                                                                        : ST_HASH;
            ST_OUT: if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // RAM write port: clearing pass or add/remove write-back
    always_comb
    begin
        we = 1'b0;
        waddr = addr_reg;
        wdata = cell_new;
        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            ST_MODIFY: we = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_REMOVE);
            default: we = 1'b0;
        endcase
    end

    // result word and output valid
    assign out_load = (state_reg == ST_OUT) && (state_next == ST_IDLE);

    always_comb
    begin
        out_data_next = '0;
        case (cmd_reg)
            CMD_TEST: out_data_next[0] = member_reg;
            CMD_READ:
            begin
                if (32'(tsel_reg) >= 32'(NUM_HASHES))
                begin
                    out_data_next[33] = 1'b1;
                end
                else
                begin
                    out_data_next[32:1] = rdata[KeyBits-1:0];
                    out_data_next[33] = zero;
                    out_data_next[34] = cell_is_pure;
                    out_data_next[66:35] = pkey;
                end
            end
            default: out_data_next = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready) out_valid_next = 1'b0;
        if (out_load) out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + AddrBits'(1);
            out_valid_reg <= out_valid_next;
        end
    end
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg <= cmd_t'(s_axis_tdata[1:0]);
                key_reg <= s_axis_tdata[33:2];
                tsel_reg <= s_axis_tdata[35:34];
                tbl_reg <= '0;
                member_reg <= 1'b1;
                addr_reg <= read_addr;
            end
            ST_HASH: addr_reg <= hash_addr;
            ST_MODIFY:
            begin
                if (zero) member_reg <= 1'b0;
                tbl_reg <= tbl_reg + (TblBits+1)'(1);
            end
            default: ;
        endcase
        if (out_load) out_data_reg <= out_data_next;
    end

    `include "assert_macros.svh"
    `ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !s_axis_tready)
    `ASSERT_IMP(a_wr_only_update, clk, rst_n, we && state_reg != ST_CLEAR,
                cmd_reg == CMD_ADD || cmd_reg == CMD_REMOVE)
    `ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire
